FILE: hw/rtl/rdcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcl_pkg
// shared types, constants and helpers for the riff data chunk locator
// ----------------------------------------------------------------------------
package rdcl_pkg;

    // byte positions are kept in 17 bits, saturating; anything past 16 bits
    // can never pass the header limit check
    localparam int unsigned POS_W       = 17;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] FIRST_HDR_POS = POS_W'(12);
    localparam int unsigned HDR_LEN     = 8;
    localparam logic [15:0] SCAN_LIMIT_RST = 16'd32768;

    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_T = 8'h74;

    localparam logic STATUS_FOUND     = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_HEADER = 3'b010,
        PH_DONE   = 3'b100
    } t_phase;

    typedef struct packed {
        logic        status;
        logic [15:0] data_offset;
        logic [31:0] chunk_size;
    } t_result;

    // expected identifier byte at header position 0..3
    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CH_D;
            2'd1:    ch = CH_A;
            2'd2:    ch = CH_T;
            default: ch = CH_A;
        endcase
        return ch;
    endfunction

endpackage

FILE: hw/rtl/riff_data_chunk_locator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riff_data_chunk_locator
// finds the "data" chunk of a RIFF/WAV byte stream and reports its size
// ----------------------------------------------------------------------------
// Feed the file one byte per item, with i_stream_start high on its first
// byte. The block skips the 12-byte file header, walks the chunk headers
// (4-byte id, 4-byte little-endian size, odd sizes padded by one byte) and
// gives at most one result per stream: status 0 with the header offset and
// size of the "data" chunk, or status 1 (offset and size zero) once the next
// header would end past scan_limit. Bytes after the result are swallowed
// until the next stream start. One byte is taken every clock cycle; a result
// passes the input register and then the queue head register. The rate is
// set by the single-cycle parser step, the longest path being the 34-bit
// next-header add with its saturation and limit compare. Input only stalls
// while two results wait unread in the output queue. scan_limit (reset
// 32768) may be rewritten between streams or while no byte is in flight.
// ----------------------------------------------------------------------------
module riff_data_chunk_locator
    import rdcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // byte stream in
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_start,

    // result out
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [15:0] o_data_offset,
    output logic [31:0] o_chunk_size,

    // scan limit register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_scan_limit
);

    logic [15:0] r_scan_limit;

    // input register stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;

    logic        w_space;
    logic        w_step;
    logic        w_emit;
    t_result     w_res;
    t_result     w_head;

    // the parser steps whenever a byte is held and the queue has room
    assign w_step     = r_in_valid & w_space;
    assign o_in_ready = ~r_in_valid | w_space;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_limit <= SCAN_LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_scan_limit <= i_cfg_scan_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_stream_start;
        end
    end

    rdcl_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_scan_limit   (r_scan_limit),
        .i_en           (w_step),
        .i_data_byte    (r_in_byte),
        .i_stream_start (r_in_start),
        .o_emit         (w_emit),
        .o_result       (w_res)
    );

    // two result slots so a waiting result does not hold up the byte stream
    rdcl_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_emit),
        .i_data  (w_res),
        .o_space (w_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_head)
    );

    assign o_status      = w_head.status;
    assign o_data_offset = w_head.data_offset;
    assign o_chunk_size  = w_head.chunk_size;

`ifndef SYNTH
    a_no_result_without_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_step)
        else $error("result produced without a byte in the parser");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_res.status == STATUS_NOT_FOUND)
            |-> (w_res.data_offset == 16'd0 && w_res.chunk_size == 32'd0))
        else $error("not-found result carries nonzero fields");

    a_held_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_space) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled byte lost from input register");
`endif

endmodule

FILE: hw/rtl/rdcl_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcl_parser
// one-byte-per-cycle (while enabled) chunk header parser with its state registers
// ----------------------------------------------------------------------------
module rdcl_parser
    import rdcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_scan_limit,
    input  logic        i_en,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_start,
    output logic        o_emit,
    output t_result     o_result
);

    logic [POS_W-1:0] r_bp, n_bp;
    logic [POS_W-1:0] r_hp, n_hp;
    logic [2:0]       r_idx, n_idx;
    logic             r_match, n_match;
    logic [31:0]      r_size, n_size;
    t_phase           r_phase, n_phase;

    logic             w_emit;
    t_result          w_res;

    always_comb begin
        logic [POS_W-1:0] e_bp;
        logic [POS_W-1:0] e_hp;
        logic             fits;
        logic             fits_next;
        logic [33:0]      sum;
        logic [POS_W-1:0] hp_sat;

        // restart on stream start, this byte then counts as offset 0
        e_bp    = i_stream_start ? '0 : r_bp;
        e_hp    = i_stream_start ? FIRST_HDR_POS : r_hp;
        n_idx   = i_stream_start ? 3'd0 : r_idx;
        n_match = i_stream_start ? 1'b1 : r_match;
        n_size  = i_stream_start ? 32'd0 : r_size;
        n_phase = i_stream_start ? PH_SKIP : r_phase;
        n_hp    = e_hp;
        n_bp    = (e_bp != POS_MAX) ? e_bp + POS_W'(1) : e_bp;

        w_emit  = 1'b0;
        w_res   = '{status: STATUS_NOT_FOUND, data_offset: 16'd0, chunk_size: 32'd0};
        sum       = '0;
        hp_sat    = '0;
        fits_next = 1'b0;

        fits = ({1'b0, e_hp} + (POS_W+1)'(HDR_LEN)) <= (POS_W+1)'(i_scan_limit);

        unique case (n_phase)
            PH_SKIP: begin
                if (!fits) begin
                    w_emit  = 1'b1;
                    n_phase = PH_DONE;
                end else if (e_bp >= e_hp) begin
                    n_phase = PH_HEADER;
                    n_idx   = 3'd0;
                    n_match = 1'b1;
                    n_size  = 32'd0;
                end
            end
            PH_HEADER: ;
            default: n_phase = PH_DONE;
        endcase

        if (n_phase == PH_HEADER) begin
            if (!n_idx[2]) begin
                if (i_data_byte != tag_byte(n_idx[1:0]))
                    n_match = 1'b0;
            end else begin
                case (n_idx[1:0])
                    2'd0:    n_size[7:0]   = n_size[7:0]   | i_data_byte;
                    2'd1:    n_size[15:8]  = n_size[15:8]  | i_data_byte;
                    2'd2:    n_size[23:16] = n_size[23:16] | i_data_byte;
                    default: n_size[31:24] = n_size[31:24] | i_data_byte;
                endcase
            end
            if (n_idx == 3'd7) begin
                if (n_match) begin
                    w_emit  = 1'b1;
                    w_res   = '{status: STATUS_FOUND, data_offset: e_hp[15:0],
                                chunk_size: n_size};
                    n_phase = PH_DONE;
                end else begin
                    // next header after this chunk plus its pad byte
                    sum = 34'(e_hp) + 34'(HDR_LEN) + 34'(n_size) + 34'(n_size[0]);
                    hp_sat = (sum > 34'(POS_MAX)) ? POS_MAX : sum[POS_W-1:0];
                    n_hp   = hp_sat;
                    fits_next = ({1'b0, hp_sat} + (POS_W+1)'(HDR_LEN))
                                <= (POS_W+1)'(i_scan_limit);
                    n_phase = PH_SKIP;
                    if (!fits_next) begin
                        w_emit  = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                n_idx = 3'd0;
            end else begin
                n_idx = n_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp    <= '0;
            r_hp    <= FIRST_HDR_POS;
            r_idx   <= 3'd0;
            r_match <= 1'b1;
            r_size  <= 32'd0;
            r_phase <= PH_SKIP;
        end else if (i_en) begin
            r_bp    <= n_bp;
            r_hp    <= n_hp;
            r_idx   <= n_idx;
            r_match <= n_match;
            r_size  <= n_size;
            r_phase <= n_phase;
        end
    end

    assign o_emit   = i_en & w_emit;
    assign o_result = w_res;

`ifndef SYNTH
    a_emit_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> r_phase == PH_DONE)
        else $error("parser not done after a result");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && !i_stream_start) |-> !w_emit)
        else $error("result given after parser finished");

    a_skip_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> r_bp <= r_hp)
        else $error("byte position passed next header while skipping");
`endif

endmodule

FILE: hw/rtl/rdcl_out_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcl_out_q
// two-entry result queue, head register drives the output port
// ----------------------------------------------------------------------------
module rdcl_out_q
    import rdcl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_q0, r_q1;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign w_pop   = o_valid & i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_space = (r_cnt != 2'd2);
    assign o_data  = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({i_push, w_pop})
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    r_q0 <= i_data;
                end else begin
                    r_q0 <= r_q1;
                    r_q1 <= i_data;
                end
            end
            2'b10: begin
                if (r_cnt == 2'd0)
                    r_q0 <= i_data;
                else
                    r_q1 <= i_data;
            end
            2'b01: r_q0 <= r_q1;
            default: ;
        endcase
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2))
        else $error("push into full result queue");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !w_pop) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count missed a push");
`endif

endmodule
